FILE: design/mpl_pkg.sv
// Package for the marker position and line number extractor.
// Holds field widths and the sequencer state type; no dependencies.
package mpl_pkg;

  localparam int unsigned FIELD_W = 64;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

FILE: design/mpl_bit_unit.sv
// Shared bit unit: lowest set marker bit, its index, and a break popcount.
// Depends on no other file; purely combinational.
module mpl_bit_unit #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  logic [WORD_WIDTH-1:0]              marks,
  input  logic [WORD_WIDTH-1:0]              brk,
  input  logic                               sel_all,
  output logic [$clog2(WORD_WIDTH)-1:0]      idx,
  output logic [$clog2(WORD_WIDTH+1)-1:0]    cnt,
  output logic [WORD_WIDTH-1:0]              marks_rest
);

  localparam int unsigned IDX_W = $clog2(WORD_WIDTH);
  localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

  logic [WORD_WIDTH-1:0] low;
  logic [WORD_WIDTH-1:0] upto;
  logic [WORD_WIDTH-1:0] sel;

  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_WIDTH-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  always_comb begin
    low        = marks & (~marks + WORD_WIDTH'(1));
    upto       = low | (low - WORD_WIDTH'(1));
    marks_rest = marks & (marks - WORD_WIDTH'(1));
    idx        = '0;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      if (low[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    sel = sel_all ? '1 : upto;
    cnt = popcount(brk & sel);
  end

endmodule

FILE: design/marker_position_line_number.sv
// Top level of the marker position and line number extractor.
// Depends on mpl_pkg and mpl_bit_unit.
//
//   channel | dir | tdata (low bit up)                        | side band
//   in_     | in  | marker_bits[63:0], break_bits[127:64]     | -
//   out_    | out | position[63:0], line_number[127:64]       | tlast = last_of_word
//
// A word is loaded in the idle state; in the run state each of its markers goes
// through the shared bit unit in turn while the output is free, and a last step
// adds the word's break count and advances the position base.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid and
// both running counters. A stalled output holds its request and pauses the
// sequencer; a new word is still taken while the last result waits.
module marker_position_line_number #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*mpl_pkg::FIELD_W-1:0]   in_tdata,   // marker_bits, break_bits
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*mpl_pkg::FIELD_W-1:0]   out_tdata,  // position, line_number
  output logic                            out_tlast
);

  localparam int unsigned FW    = mpl_pkg::FIELD_W;
  localparam int unsigned IDX_W = $clog2(WORD_WIDTH);
  localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

  mpl_pkg::state_t state_r, state_nxt;

  logic [WORD_WIDTH-1:0] marks_r, marks_nxt;
  logic [WORD_WIDTH-1:0] brk_r, brk_nxt;
  logic [FW-1:0]         base_r, base_nxt;
  logic [FW-1:0]         before_r, before_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FW-1:0]         out_pos_r, out_pos_nxt;
  logic [FW-1:0]         out_line_r, out_line_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  sel_all;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      cnt;
  logic [WORD_WIDTH-1:0] marks_rest;
  logic                  out_free;

  mpl_bit_unit #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_bit_unit (
    .marks      (marks_r),
    .brk        (brk_r),
    .sel_all    (sel_all),
    .idx        (idx),
    .cnt        (cnt),
    .marks_rest (marks_rest)
  );

  assign in_tready  = (state_r == mpl_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_line_r, out_pos_r};
  assign out_tlast  = out_last_r;
  assign sel_all    = (marks_r == '0);
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    marks_nxt     = marks_r;
    brk_nxt       = brk_r;
    base_nxt      = base_r;
    before_nxt    = before_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_line_nxt  = out_line_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      mpl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          marks_nxt = in_tdata[WORD_WIDTH-1:0];
          brk_nxt   = in_tdata[FW+WORD_WIDTH-1:FW];
          state_nxt = mpl_pkg::ST_RUN;
        end
      end
      mpl_pkg::ST_RUN: begin
        if (sel_all) begin
          base_nxt   = base_r + FW'(WORD_WIDTH);
          before_nxt = before_r + FW'(cnt);
          state_nxt  = mpl_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = base_r + FW'(idx);
          out_line_nxt  = before_r + FW'(cnt);
          out_last_nxt  = (marks_rest == '0);
          marks_nxt     = marks_rest;
        end
      end
      default: begin
        state_nxt = mpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpl_pkg::ST_IDLE;
      base_r      <= '0;
      before_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      before_r    <= before_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    marks_r    <= marks_nxt;
    brk_r      <= brk_nxt;
    out_pos_r  <= out_pos_nxt;
    out_line_r <= out_line_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for marker_position_line_number: drives marker and break words,
// predicts every marker position and line number, and checks the result stream.
// Depends on mpl_pkg and the RTL of the block only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W        = mpl_pkg::FIELD_W;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned RANDOM_WORDS   = 317;
  localparam int unsigned SQUEEZE_AFTER  = 50;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 2 * WORD_W + 8;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] line_number;
    logic               last_of_word;
  } marker_hit_t;

  typedef struct packed {
    logic [FIELD_W-1:0] marker;
    logic [FIELD_W-1:0] brk;
    logic               typed;
    marker_hit_t        hit;
  } stim_row_t;

  typedef enum {FILL_EMPTY, FILL_SPARSE, FILL_QUARTER, FILL_DENSE, FILL_FULL} fill_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [2*FIELD_W-1:0]   in_tdata   = '0;   // marker_bits, break_bits
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*FIELD_W-1:0]   out_tdata;         // position, line_number
  logic                   out_tlast;

  logic [FIELD_W-1:0]     next_base     = '0;
  logic [FIELD_W-1:0]     breaks_so_far = '0;
  marker_hit_t            pending_hits[$];

  int unsigned            results_seen = 0;
  int unsigned            mismatches   = 0;
  int unsigned            cycles       = 0;
  int                     sender_calm  = 0;
  int                     sink_calm    = 0;

  // single-bit rows after reset have results that can be read off directly
  stim_row_t directed_rows [13] = '{
    '{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 1'b1, '{64'd0,   64'd0,   1'b1}},
    '{64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'd127, 64'd64,  1'b1}},
    '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 1'b1, '{64'd192, 64'd129, 1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b0, '0},
    '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b0, '0},
    '{64'h0000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, '0},
    '{64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
    '{64'hF000_0000_0000_000F, 64'h0F00_0000_0000_00F0, 1'b0, '0}
  };

  marker_position_line_number #(
    .WORD_WIDTH (WORD_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_cycles(inout int calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 12);
  endfunction

  function automatic fill_t pick_fill(int unsigned e, int unsigned s, int unsigned q,
                                      int unsigned d);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < e) return FILL_EMPTY;
    if (r < e + s) return FILL_SPARSE;
    if (r < e + s + q) return FILL_QUARTER;
    if (r < e + s + q + d) return FILL_DENSE;
    return FILL_FULL;
  endfunction

  function automatic logic [FIELD_W-1:0] random_bits(fill_t fill);
    logic [FIELD_W-1:0] v;
    v = '0;
    case (fill)
      FILL_EMPTY: v = '0;
      FILL_SPARSE: begin
        repeat ($urandom_range(1, 4)) v[$urandom_range(0, WORD_W - 1)] = 1'b1;
      end
      FILL_QUARTER: v = {$urandom(), $urandom()} & {$urandom(), $urandom()};
      FILL_DENSE: v = {$urandom(), $urandom()};
      default: v = '1;
    endcase
    return v;
  endfunction

  task automatic enqueue_hit(input marker_hit_t h);
    pending_hits.insert(pending_hits.size(), h);
  endtask

  // queue one hit per set marker bit when emit is set, then advance the running base and break count
  task automatic account_word(input logic [FIELD_W-1:0] marker, input logic [FIELD_W-1:0] brk,
                              input bit emit);
    logic [FIELD_W-1:0] lines;
    marker_hit_t        hit;
    lines = breaks_so_far;
    for (int i = 0; i < WORD_W; i++) begin
      lines += FIELD_W'(brk[i]);
      if (emit && marker[i]) begin
        hit.position     = next_base + FIELD_W'(i);
        hit.line_number  = lines;
        hit.last_of_word = ((marker >> i) == 1);
        enqueue_hit(hit);
      end
    end
    breaks_so_far = lines;
    next_base     = next_base + FIELD_W'(WORD_W);
  endtask

  task automatic drive_word(input logic [FIELD_W-1:0] marker, input logic [FIELD_W-1:0] brk);
    int unsigned gap;
    gap = idle_cycles(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {brk, marker};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_hits.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    marker_hit_t want;
    marker_hit_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[FIELD_W-1:0], out_tdata[2*FIELD_W-1:FIELD_W], out_tlast};
      results_seen++;
      if (pending_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: position %0d line %0d last %b",
                                got.position, got.line_number, got.last_of_word));
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          flag_mismatch($sformatf(
            "result %0d: position %0d/%0d line %0d/%0d last %b/%b (expected/actual)",
            results_seen, want.position, got.position, want.line_number, got.line_number,
            want.last_of_word, got.last_of_word));
        end
      end
    end
  end

  // hold ready low for a long stretch once, so the block backs up into its input; else stall at random
  initial begin
    int  stall_left;
    int  hold_left;
    bit  squeezed;
    stall_left = 0;
    hold_left  = 0;
    squeezed   = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!squeezed && results_seen >= SQUEEZE_AFTER) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = idle_cycles(sink_calm);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [FIELD_W-1:0] marker;
    logic [FIELD_W-1:0] brk;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k]) begin
      drive_word(directed_rows[k].marker, directed_rows[k].brk);
      if (directed_rows[k].typed && directed_rows[k].marker != '0) begin
        enqueue_hit(directed_rows[k].hit);
      end
      account_word(directed_rows[k].marker, directed_rows[k].brk, !directed_rows[k].typed);
    end
    repeat (RANDOM_WORDS) begin
      marker = random_bits(pick_fill(10, 55, 20, 10));
      brk    = random_bits(pick_fill(10, 30, 20, 30));
      drive_word(marker, brk);
      account_word(marker, brk, 1'b1);
    end
    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d directed and %0d random words through the extractor,",
             $size(directed_rows), RANDOM_WORDS);
    $display("checking %0d marker results; %0d disagreed.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mpl_pkg.sv
design/mpl_bit_unit.sv
design/marker_position_line_number.sv
bench/testbench.sv
